// ----- rtl/lpmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmr_pkg: shared definitions of the longest prefix match router
// Table sizes, result status codes, action codes, sequencer states and the prefix mask.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IFACE_COUNT = 8;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef logic [1:0] status_t;
	localparam status_t STATUS_ADDED   = 2'd0;
	localparam status_t STATUS_FULL    = 2'd1;
	localparam status_t STATUS_FORWARD = 2'd2;
	localparam status_t STATUS_DROP    = 2'd3;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_ROUTE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// Mask of the leading len bits; lengths above 32 select every bit
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = '0;
		end else if (len >= 6'd32) begin
			m = '1;
		end else begin
			m = 32'hFFFF_FFFF << (6'd32 - len);
		end
		return m;
	endfunction

endpackage

// ----- rtl/longest_prefix_match_router_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_match_router_unit: IPv4 longest prefix match route table
// Stores up to TABLE_DEPTH routes and looks up destinations one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one item at a time. action 0
//   appends a route; action 1 looks up dest_addr and decrements ttl_in.
//   Output channel (out_valid / out_stall) gives one result per item:
//   status, out_iface, hop_addr, ttl_out.
// Timing:
//   An add item passes from acceptance through the finishing state into the
//   registered result. A route item first walks the n stored routes one entry
//   a cycle through a single registered read port and one shared
//   mask-and-compare unit, then passes through the finishing state. The next
//   item is taken once the sequencer is back in idle after the result is
//   loaded; the block takes no new item while one is still in work.
// Reset:
//   arst_n clears the route count, the sequencer and the output valid. The
//   route store itself is not cleared; only entries below the count are read.
// Back-pressure:
//   While out_stall is high the result holds. A new item may already be
//   accepted and worked on; its result waits in the finishing state until
//   the output register is free.
// ----------------------------------------------------------------------------
module longest_prefix_match_router_unit
	import lpmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [31:0] route_prefix_in,
	input  logic [5:0]  prefix_len_in,
	input  logic        has_next_hop,
	input  logic [31:0] next_hop_in,
	input  logic [2:0]  iface_in,
	input  logic [31:0] dest_addr,
	input  logic [7:0]  ttl_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  out_iface,
	output logic [31:0] hop_addr,
	output logic [7:0]  ttl_out
);

	// Route store
	logic [31:0] pfx_mem [TABLE_DEPTH];
	logic [5:0]  len_mem [TABLE_DEPTH];
	logic [31:0] gw_mem  [TABLE_DEPTH];
	logic        dir_mem [TABLE_DEPTH];
	logic [2:0]  ifc_mem [TABLE_DEPTH];

	state_t     state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;

	logic        act_q;
	logic        full_q;
	logic [31:0] dst_q;
	logic [7:0]  ttl_q;

	logic        rd_vld_q;
	logic [31:0] rd_pfx_q;
	logic [5:0]  rd_len_q;
	logic [31:0] rd_gw_q;
	logic        rd_dir_q;
	logic [2:0]  rd_ifc_q;

	logic        found_q;
	logic [5:0]  best_len_q;
	logic [31:0] best_gw_q;
	logic        best_dir_q;
	logic [2:0]  best_ifc_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [2:0]  out_iface_q;
	logic [31:0] hop_addr_q;
	logic [7:0]  ttl_out_q;

	logic        in_acc;
	logic        out_free;
	logic        scan_end;
	logic        rd_en;
	logic        load_out;
	logic        add_ok;
	logic        hit;
	logic        better;
	logic        fwd;
	logic [5:0]  len_sat;
	status_t     res_status;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign scan_end = (idx_q == count_q);
	assign add_ok   = (count_q < CNT_W'(TABLE_DEPTH));
	assign len_sat  = (prefix_len_in > 6'd32) ? 6'd32 : prefix_len_in;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (action == ACT_ROUTE) ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE:   in_stall = 1'b0;
			S_SCAN:   rd_en    = !scan_end;
			S_FINISH: load_out = out_free;
			default:  in_stall = 1'b1;
		endcase
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= rd_en;
			if (in_acc) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				if (action == ACT_ADD && add_ok) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Write an added route
	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_ADD && add_ok) begin
			pfx_mem[count_q[IDX_W-1:0]] <= route_prefix_in;
			len_mem[count_q[IDX_W-1:0]] <= len_sat;
			gw_mem[count_q[IDX_W-1:0]]  <= next_hop_in;
			dir_mem[count_q[IDX_W-1:0]] <= !has_next_hop;
			ifc_mem[count_q[IDX_W-1:0]] <= iface_in;
		end
	end

	// Read one entry a cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pfx_q <= pfx_mem[idx_q[IDX_W-1:0]];
			rd_len_q <= len_mem[idx_q[IDX_W-1:0]];
			rd_gw_q  <= gw_mem[idx_q[IDX_W-1:0]];
			rd_dir_q <= dir_mem[idx_q[IDX_W-1:0]];
			rd_ifc_q <= ifc_mem[idx_q[IDX_W-1:0]];
		end
	end

	// Shared compare: match under mask, keep strictly longer prefixes only
	assign hit    = rd_vld_q && (((dst_q ^ rd_pfx_q) & len_mask(rd_len_q)) == 32'd0);
	assign better = hit && (!found_q || rd_len_q > best_len_q);

	// Hold the item and the best route so far
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= action;
			full_q <= !add_ok;
			dst_q  <= dest_addr;
			ttl_q  <= ttl_in;
		end
		if (better) begin
			best_len_q <= rd_len_q;
			best_gw_q  <= rd_gw_q;
			best_dir_q <= rd_dir_q;
			best_ifc_q <= rd_ifc_q;
		end
	end

	// Form the result
	assign fwd = found_q && (ttl_q > 8'd1) && (32'(best_ifc_q) < IFACE_COUNT);

	always_comb begin
		if (act_q == ACT_ADD) begin
			res_status = full_q ? STATUS_FULL : STATUS_ADDED;
		end else begin
			res_status = fwd ? STATUS_FORWARD : STATUS_DROP;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= res_status;
			if (act_q == ACT_ROUTE && fwd) begin
				out_iface_q <= best_ifc_q;
				hop_addr_q  <= best_dir_q ? dst_q : best_gw_q;
				ttl_out_q   <= ttl_q - 8'd1;
			end else begin
				out_iface_q <= '0;
				hop_addr_q  <= '0;
				ttl_out_q   <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_iface = out_iface_q;
	assign hop_addr  = hop_addr_q;
	assign ttl_out   = ttl_out_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("route count beyond table depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= count_q))
		else $error("scan index passed route count");

	a_route_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == ACT_ROUTE) |=> (state_q == S_SCAN && idx_q == '0))
		else $error("route item did not start a scan");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == ACT_ADD && add_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("added route not counted");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
		else $error("result loaded outside finishing state");

endmodule

// ----- tb/sv/tb_longest_prefix_match_router_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_prefix_match_router_unit: self-checking bench of the route table
// Runs directed items, then fills the table with overlapping routes amid
// lookups aimed at the stored prefixes and random addresses, under random
// input gaps and output stalls. A route table model predicts every result,
// and each result leaving the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_longest_prefix_match_router_unit;
	import lpmr_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RANDOM_ITEMS   = 1725;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 2 * (TABLE_DEPTH + 4);
	localparam int REPORT_LIMIT   = 10;
	localparam int DEFAULT_AT     = 700;
	localparam int PAUSE_AT       = 1000;

	typedef struct {
		logic        action;
		logic [31:0] prefix;
		logic [5:0]  plen;
		logic        gw_flag;
		logic [31:0] gateway;
		logic [2:0]  iface;
		logic [31:0] dest;
		logic [7:0]  ttl;
	} route_item_t;

	typedef struct {
		status_t     status;
		logic [2:0]  iface;
		logic [31:0] hop;
		logic [7:0]  ttl;
	} route_result_t;

	// Route table model: own copy of the stored routes and the queue of
	// results still owed by the block
	class route_table_model;
		logic [31:0]   prefix_tbl[TABLE_DEPTH];
		logic [5:0]    len_tbl[TABLE_DEPTH];
		logic [31:0]   gateway_tbl[TABLE_DEPTH];
		logic          direct_tbl[TABLE_DEPTH];
		logic [2:0]    iface_tbl[TABLE_DEPTH];
		int unsigned   route_count;
		route_result_t owed_results[$];
		int unsigned   errors;

		function new();
			route_count = 0;
			errors = 0;
		endfunction

		static function logic [31:0] prefix_mask(logic [5:0] plen);
			return ~(32'hFFFF_FFFF >> plen);
		endfunction

		function route_result_t resolve_item(route_item_t it);
			route_result_t r;
			logic [31:0]   m;
			int unsigned   best;
			bit            found;
			r = '{STATUS_DROP, 3'd0, 32'd0, 8'd0};
			if (it.action == ACT_ADD) begin
				if (route_count >= TABLE_DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					prefix_tbl[route_count]  = it.prefix;
					len_tbl[route_count]     = (it.plen > 6'd32) ? 6'd32 : it.plen;
					gateway_tbl[route_count] = it.gateway;
					direct_tbl[route_count]  = ~it.gw_flag;
					iface_tbl[route_count]   = it.iface;
					route_count++;
					r.status = STATUS_ADDED;
				end
				return r;
			end
			// Walk the table; a strictly longer match replaces the current best
			found = 1'b0;
			best = 0;
			for (int unsigned i = 0; i < route_count; i++) begin
				m = prefix_mask(len_tbl[i]);
				if ((it.dest & m) == (prefix_tbl[i] & m)) begin
					if (!found || len_tbl[i] > len_tbl[best]) begin
						best = i;
						found = 1'b1;
					end
				end
			end
			if (!found || it.ttl <= 8'd1 || int'(iface_tbl[best]) >= IFACE_COUNT) begin
				return r;
			end
			r.status = STATUS_FORWARD;
			r.iface  = iface_tbl[best];
			r.hop    = direct_tbl[best] ? it.dest : gateway_tbl[best];
			r.ttl    = it.ttl - 8'd1;
			return r;
		endfunction

		function void note_item(route_item_t it);
			owed_results.insert(owed_results.size(), resolve_item(it));
		endfunction

		function void check_result(route_result_t got);
			route_result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected item: status=%0d iface=%0d hop=%h ttl=%0d",
						got.status, got.iface, got.hop, got.ttl);
				return;
			end
			want = owed_results.pop_front();
			if (got.status !== want.status || got.iface !== want.iface ||
					got.hop !== want.hop || got.ttl !== want.ttl) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$write("mismatch: expected status=%0d iface=%0d hop=%h ttl=%0d,",
						want.status, want.iface, want.hop, want.ttl);
					$display(" got status=%0d iface=%0d hop=%h ttl=%0d",
						got.status, got.iface, got.hop, got.ttl);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [31:0] route_prefix_in;
	logic [5:0]  prefix_len_in;
	logic        has_next_hop;
	logic [31:0] next_hop_in;
	logic [2:0]  iface_in;
	logic [31:0] dest_addr;
	logic [7:0]  ttl_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [2:0]  out_iface;
	logic [31:0] hop_addr;
	logic [7:0]  ttl_out;

	route_table_model routes;
	int unsigned      results_seen = 0;
	int unsigned      idle_cycles = 0;
	int unsigned      burst_left = 0;
	int unsigned      routes_sent = 0;
	bit               hold_done = 1'b0;

	longest_prefix_match_router_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.route_prefix_in (route_prefix_in),
		.prefix_len_in   (prefix_len_in),
		.has_next_hop    (has_next_hop),
		.next_hop_in     (next_hop_in),
		.iface_in        (iface_in),
		.dest_addr       (dest_addr),
		.ttl_in          (ttl_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.out_iface       (out_iface),
		.hop_addr        (hop_addr),
		.ttl_out         (ttl_out)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Build an add item; the lookup side carries noise
	function automatic route_item_t make_add(logic [31:0] prefix, logic [5:0] plen,
			logic gw_flag, logic [31:0] gateway, logic [2:0] iface);
		route_item_t it;
		it.action  = ACT_ADD;
		it.prefix  = prefix;
		it.plen    = plen;
		it.gw_flag = gw_flag;
		it.gateway = gateway;
		it.iface   = iface;
		it.dest    = $urandom;
		it.ttl     = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// Build a lookup item; the route side carries noise
	function automatic route_item_t make_lookup(logic [31:0] dest, logic [7:0] ttl);
		route_item_t it;
		it = make_add($urandom, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
			$urandom, 3'($urandom_range(0, 7)));
		it.action = ACT_ROUTE;
		it.dest   = dest;
		it.ttl    = ttl;
		return it;
	endfunction

	// New route, often nested in or equal in length to a stored one
	function automatic route_item_t random_route();
		int unsigned pick;
		int unsigned base;
		int unsigned plen;
		logic [31:0] pfx;
		logic [31:0] m;
		pfx = $urandom;
		plen = $urandom_range(1, 32);
		pick = $urandom_range(0, 9);
		if (routes.route_count > 0 && pick < 5) begin
			base = $urandom_range(0, routes.route_count - 1);
			m = route_table_model::prefix_mask(routes.len_tbl[base]);
			pfx = (routes.prefix_tbl[base] & m) | ($urandom & ~m);
			plen = int'(routes.len_tbl[base]);
			if (pick > 1)
				plen = plen + $urandom_range(1, 8);
			if (plen > 32)
				plen = 32;
		end else if (pick == 9) begin
			plen = $urandom_range(33, 63);
		end
		return make_add(pfx, 6'(plen), 1'($urandom_range(0, 1)), $urandom,
			3'($urandom_range(0, 7)));
	endfunction

	// Lookup mostly aimed inside a stored prefix, with TTL values of 0 and 1 now and then
	function automatic route_item_t random_lookup();
		int unsigned base;
		logic [31:0] m;
		logic [31:0] dest;
		logic [7:0]  ttl;
		dest = $urandom;
		if (routes.route_count > 0 && $urandom_range(0, 9) < 7) begin
			base = $urandom_range(0, routes.route_count - 1);
			m = route_table_model::prefix_mask(routes.len_tbl[base]);
			dest = (routes.prefix_tbl[base] & m) | ($urandom & ~m);
		end
		if ($urandom_range(0, 9) == 0)
			ttl = 8'($urandom_range(0, 1));
		else
			ttl = 8'($urandom_range(0, 255));
		return make_lookup(dest, ttl);
	endfunction

	// Offer one item and hold it until the block takes it
	task automatic drive_item(input route_item_t it);
		@(negedge clk);
		in_valid        <= 1'b1;
		action          <= it.action;
		route_prefix_in <= it.prefix;
		prefix_len_in   <= it.plen;
		has_next_hop    <= it.gw_flag;
		next_hop_in     <= it.gateway;
		iface_in        <= it.iface;
		dest_addr       <= it.dest;
		ttl_in          <= it.ttl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		routes.note_item(it);
		if (it.action == ACT_ADD)
			routes_sent++;
	endtask

	task automatic idle_sender(input int unsigned cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Send in bursts of random length, mostly with random gaps between them
	task automatic send_paced(input route_item_t it);
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) != 0)
				idle_sender($urandom_range(1, 20));
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
		drive_item(it);
	endtask

	task automatic wait_results_drained();
		idle_sender(1);
		burst_left = 0;
		while (routes.owed_results.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: stall on a changing pattern, with one long hold-off
	initial begin : receiver
		int unsigned mode;
		int unsigned phase_left;
		int unsigned tick;
		out_stall = 1'b0;
		mode = 0;
		phase_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(50, 300);
			end
			phase_left--;
			tick++;
			case (mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				2: begin
					out_stall <= ($urandom_range(0, 9) < 7);
				end
				default: begin
					out_stall <= ((tick % 7) < 3);
				end
			endcase
		end
	end

	// Check every result that leaves the block
	always @(posedge clk) begin
		route_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, out_iface, hop_addr, ttl_out};
			routes.check_result(got);
			results_seen++;
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_longest_prefix_match_router_unit: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		route_item_t it;
		routes = new();
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		action          = ACT_ADD;
		route_prefix_in = '0;
		prefix_len_in   = '0;
		has_next_hop    = 1'b0;
		next_hop_in     = '0;
		iface_in        = '0;
		dest_addr       = '0;
		ttl_in          = '0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, nesting, TTL limits, ties, extremes, odd lengths
		send_paced(make_lookup(32'h0000_0000, 8'd64));
		send_paced(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 3'd1));
		send_paced(make_lookup(32'h0A01_0203, 8'd64));
		send_paced(make_lookup(32'h0B00_0001, 8'd64));
		send_paced(make_add(32'h0A01_0000, 6'd16, 1'b0, 32'h1234_5678, 3'd2));
		send_paced(make_lookup(32'h0A01_0203, 8'd255));
		send_paced(make_lookup(32'h0A02_0000, 8'd2));
		send_paced(make_lookup(32'h0A01_0203, 8'd1));
		send_paced(make_lookup(32'h0A01_0203, 8'd0));
		send_paced(make_add(32'h0A01_0000, 6'd16, 1'b1, 32'hDEAD_BEEF, 3'd3));
		send_paced(make_lookup(32'h0A01_0909, 8'd10));
		send_paced(make_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 3'd7));
		send_paced(make_lookup(32'hFFFF_FFFF, 8'd255));
		send_paced(make_lookup(32'hFFFF_FFFE, 8'd255));
		send_paced(make_add(32'hC0A8_0155, 6'd40, 1'b0, 32'hFFFF_FFFF, 3'd4));
		send_paced(make_lookup(32'hC0A8_0155, 8'd33));
		send_paced(make_lookup(32'hC0A8_0154, 8'd33));
		send_paced(make_add(32'hAC1F_FFFF, 6'd12, 1'b1, 32'hFFFF_FFFF, 3'd5));
		send_paced(make_lookup(32'hAC10_0000, 8'd128));
		send_paced(make_add(32'h0000_0000, 6'd63, 1'b1, 32'h8000_0001, 3'd0));
		send_paced(make_lookup(32'h0000_0000, 8'd128));
		send_paced(make_lookup(32'h0000_0001, 8'd128));
		wait_results_drained();

		// Random: fill the table in the early part, default route last,
		// then adds only hit a full table
		for (int unsigned idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (idx == PAUSE_AT)
				wait_results_drained();
			if (idx % 80 == 40 && routes_sent < TABLE_DEPTH - 1)
				it = random_route();
			else if (idx == DEFAULT_AT && routes_sent < TABLE_DEPTH)
				it = make_add($urandom, 6'd0, 1'b1, $urandom, 3'd6);
			else if (routes_sent >= TABLE_DEPTH && $urandom_range(0, 9) == 0)
				it = make_add($urandom, 6'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
			else
				it = random_lookup();
			send_paced(it);
		end

		wait_results_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (routes.errors == 0 && routes.owed_results.size() == 0)
			$display("tb_longest_prefix_match_router_unit: done, clean");
		else
			$display("tb_longest_prefix_match_router_unit: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lpmr_pkg.sv
rtl/longest_prefix_match_router_unit.sv
tb/sv/tb_longest_prefix_match_router_unit.sv
